>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the sorted-set block.
// Relies on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define SSID_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sorted set assertion failed");

// Check that a condition never holds outside reset.
`define SSID_NEVER(lbl, cond) \
  `SSID_ASSERT(lbl, !(cond))

`endif

>>> hw/rtl/ssid_pkg.sv
// Package for the sorted-set block: transaction structs, operation codes
// and cell control. No dependencies.
`default_nettype none

package ssid_pkg;

  localparam int unsigned MaxOut = 16;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_DUMP   = 2'd2
  } ssid_op_e;

  typedef enum logic [1:0] {
    KIND_ACK   = 2'd0,
    KIND_ELEM  = 2'd1,
    KIND_EMPTY = 2'd2
  } ssid_kind_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } ssid_cell_op_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_DUMP = 1'b1
  } ssid_state_e;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] operand_value;
  } ssid_in_t;

  typedef struct packed {
    logic [1:0]         result_kind;
    logic signed [31:0] element_value;
    logic               last_flag;
    logic               changed_flag;
    logic               full_drop_flag;
    logic [4:0]         entry_count;
  } ssid_out_t;

  // Broadcast from the controller to every cell.
  typedef struct packed {
    ssid_cell_op_e      op;
    logic signed [31:0] operand;
  } ssid_cell_ctrl_t;

endpackage

`default_nettype wire

>>> hw/rtl/ssid_cell.sv
// One cell of the sorted chain: holds one value, compares it against the
// broadcast operand and takes a neighbour's value on shifts. Uses ssid_pkg.
`default_nettype none

module ssid_cell
  import ssid_pkg::*;
(
  input  wire logic               clk_i,
  input  wire ssid_cell_ctrl_t    ctrl_i,
  input  wire logic               occupied_i,
  input  wire logic               left_less_i,
  input  wire logic signed [31:0] left_val_i,
  input  wire logic signed [31:0] right_val_i,
  output logic                    less_o,
  output logic                    eq_o,
  output logic signed [31:0]      val_o
);

  logic signed [31:0] val_q, val_d;

  // Compare the held value with the operand
  assign less_o = occupied_i && (val_q < ctrl_i.operand);
  assign eq_o   = occupied_i && (val_q == ctrl_i.operand);
  assign val_o  = val_q;

  // Pick the next value: open a gap, close a gap or rotate
  always_comb begin
    val_d = val_q;
    unique case (ctrl_i.op)
      CELL_HOLD: val_d = val_q;
      CELL_INSERT: begin
        if (!less_o) begin
          val_d = left_less_i ? ctrl_i.operand : left_val_i;
        end
      end
      CELL_DELETE: begin
        if (!less_o) begin
          val_d = right_val_i;
        end
      end
      CELL_ROTATE: val_d = right_val_i;
      default: val_d = val_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

`default_nettype wire

>>> hw/rtl/sorted_set_insert_delete_top.sv
// Top level of the sorted-set block: controller, entry count, output
// register and the chain of ssid_cell instances. Uses ssid_pkg and macros.
//
//  channel | direction | handshake                | payload
//  in      | input     | in_valid_i / in_ready_o  | in_data_i  (ssid_in_t)
//  out     | output    | out_valid_o / out_ready_i| out_data_o (ssid_out_t)
//
// Insert and delete are done in place: every cell compares in parallel and
// the chain shifts by one place in the same edge.
// A dump rotates the ring of cells once, stalling on a full output register,
// emitting cell 0 while fewer than min(count, 16) values have gone out.
// No input is taken during a dump or while the output register stays full.
// Reset clears the entry count, rotation index, controller and output valid only.
`default_nettype none

`include "assert_macros.svh"

module sorted_set_insert_delete_top
  import ssid_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire ssid_in_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output ssid_out_t      out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned LimW = (CntW > 5) ? CntW : 5;

  ssid_state_e       state_q, state_d;
  logic [CntW-1:0]   count_q, count_d;
  logic [IdxW-1:0]   rot_q, rot_d;
  logic              out_valid_q, out_valid_d;
  ssid_out_t         out_q, out_d;

  ssid_cell_ctrl_t    cell_ctrl;
  logic [CAPACITY-1:0] less_w, eq_w;
  logic signed [31:0] val_w [CAPACITY];

  logic            accept, out_free, found, full, do_insert, do_delete;
  logic            dump_emit, dump_last, dump_step, dump_done, load_out;
  logic [LimW-1:0] cnt_ext, dump_lim, rot_ext;

  // Build the chain; cell 0 sees a "less" left neighbour, the ends wrap
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int unsigned Left  = (i == 0) ? CAPACITY - 1 : i - 1;
    localparam int unsigned Right = (i == CAPACITY - 1) ? 0 : i + 1;
    logic left_less;
    logic occupied;
    assign left_less = (i == 0) ? 1'b1 : less_w[Left];
    assign occupied  = CntW'(i) < count_q;
    ssid_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (cell_ctrl),
      .occupied_i  (occupied),
      .left_less_i (left_less),
      .left_val_i  (val_w[Left]),
      .right_val_i (val_w[Right]),
      .less_o      (less_w[i]),
      .eq_o        (eq_w[i]),
      .val_o       (val_w[i])
    );
  end

  // Decode the set state for the incoming transaction
  assign found     = |eq_w;
  assign full      = count_q == CntW'(CAPACITY);
  assign out_free  = !out_valid_q || out_ready_i;
  assign accept    = in_valid_i && in_ready_o;
  assign do_insert = accept && (in_data_i.opcode == OP_INSERT) && !found && !full;
  assign do_delete = accept && (in_data_i.opcode == OP_DELETE) && found;

  // Dump window: emit while the rotation index is below min(count, 16)
  assign cnt_ext   = LimW'(count_q);
  assign dump_lim  = (cnt_ext > LimW'(MaxOut)) ? LimW'(MaxOut) : cnt_ext;
  assign rot_ext   = LimW'(rot_q);
  assign dump_emit = rot_ext < dump_lim;
  assign dump_last = rot_ext == (dump_lim - LimW'(1));
  assign dump_step = (state_q == ST_DUMP) && (dump_emit ? out_free : 1'b1);
  assign dump_done = dump_step && (rot_q == IdxW'(CAPACITY - 1));

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (in_data_i.opcode == OP_DUMP) && (count_q != '0)) begin
          state_d = ST_DUMP;
        end
      end
      ST_DUMP: begin
        if (dump_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Controller outputs: input ready, cell command, output load
  always_comb begin
    in_ready_o        = 1'b0;
    cell_ctrl.op      = CELL_HOLD;
    cell_ctrl.operand = in_data_i.operand_value;
    load_out          = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = out_free;
        if (do_insert) begin
          cell_ctrl.op = CELL_INSERT;
        end else if (do_delete) begin
          cell_ctrl.op = CELL_DELETE;
        end
        load_out = accept && !((in_data_i.opcode == OP_DUMP) && (count_q != '0));
      end
      ST_DUMP: begin
        if (dump_step) begin
          cell_ctrl.op = CELL_ROTATE;
        end
        load_out = dump_step && dump_emit;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // Entry count and rotation index
  always_comb begin
    count_d = count_q;
    if (do_insert) begin
      count_d = count_q + CntW'(1);
    end else if (do_delete) begin
      count_d = count_q - CntW'(1);
    end
    rot_d = rot_q;
    if (dump_done) begin
      rot_d = '0;
    end else if (dump_step) begin
      rot_d = rot_q + IdxW'(1);
    end
  end

  // Form the result for the output register
  always_comb begin
    out_d                = '0;
    out_d.entry_count    = 5'(count_d);
    out_d.last_flag      = 1'b1;
    if (state_q == ST_DUMP) begin
      out_d.result_kind   = KIND_ELEM;
      out_d.element_value = val_w[0];
      out_d.last_flag     = dump_last;
    end else begin
      unique case (in_data_i.opcode)
        OP_INSERT: begin
          out_d.result_kind    = KIND_ACK;
          out_d.changed_flag   = do_insert;
          out_d.full_drop_flag = !found && full;
        end
        OP_DELETE: begin
          out_d.result_kind  = KIND_ACK;
          out_d.changed_flag = do_delete;
        end
        OP_DUMP: out_d.result_kind = KIND_EMPTY;
        default: out_d.result_kind = KIND_ACK;
      endcase
    end
  end

  // Hold a result until the sink takes it
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      rot_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rot_q       <= rot_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SSID_NEVER(a_count_bound, count_q > CntW'(CAPACITY))
  `SSID_ASSERT(a_dump_blocks_input, (state_q == ST_DUMP) |-> !in_ready_o)
  `SSID_ASSERT(a_insert_counts, do_insert |=> (count_q == $past(count_q) + CntW'(1)))
  `SSID_NEVER(a_load_over_full, load_out && out_valid_q && !out_ready_i)

endmodule

`default_nettype wire
